// ===== hw/rtl/logtab_pkg.sv =====
// Package for the log table: sizes, command and status codes, the state
// encoding and the transaction structs of both channels.
// No dependencies.
`default_nettype none

package logtab_pkg;

    // Table geometry.
    localparam int ENTRIES     = 8192;
    localparam int ENTRY_BYTES = 8;
    localparam int ENTRY_SHIFT = $clog2(ENTRY_BYTES);
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int CNT_W       = $clog2(ENTRIES + 1);

    // Field widths of the transactions.
    localparam int ID_W    = 16;
    localparam int DATA_W  = 48;
    localparam int WORD_W  = ID_W + DATA_W;
    localparam int COUNT_W = 14;
    localparam int FREE_W  = 17;

    // Table size in the widths used for position arithmetic.
    localparam logic [IDX_W:0]   ENT_WRAP = (IDX_W + 1)'(ENTRIES);
    localparam logic [CNT_W-1:0] ENT_FULL = CNT_W'(ENTRIES);

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_ERASE = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_EVICTED = 3'd1,
        ST_FOUND   = 3'd2,
        ST_ERASED  = 3'd3,
        ST_MISSING = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_EMIT
    } state_t;

    typedef struct packed {
        cmd_t              command;
        logic [ID_W-1:0]   log_id;
        logic [DATA_W-1:0] log_data;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [DATA_W-1:0]  found_data;
        logic [COUNT_W-1:0] entry_count;
        logic [FREE_W-1:0]  free_bytes;
    } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/log_table_with_id_lookup.sv =====
// Top level of the log table: entry memory, search and compaction sequencer
// and the result register. Depends on logtab_pkg.
`default_nettype none

// The table keeps up to 8192 entries (16-bit id, 48-bit data) in insertion
// order, held as a ring in a single 8192 x 64 synchronous memory with one read
// and one write per cycle; a head pointer marks the oldest entry, so evicting
// on a full write costs nothing. A write or a utilisation query needs no
// search. A read scans from the newest entry backwards, one memory read per
// cycle. An erase scans from the oldest entry to the first match at
// position p and then moves every later entry down one place, one read and
// one write per cycle. A new transaction is accepted while the previous
// result still waits in the output register. No clearing pass is needed
// after reset.
module log_table_with_id_lookup (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  logtab_pkg::in_item_t  s_item,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logtab_pkg::out_item_t m_item
);
    import logtab_pkg::*;

    // Map a position in insertion order to a memory address.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] lpos);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, lpos[IDX_W-1:0]};
        if (sum >= ENT_WRAP) begin
            sum = sum - ENT_WRAP;
        end
        return sum[IDX_W-1:0];
    endfunction

    // Entry memory and its read register.
    logic [WORD_W-1:0] mem [ENTRIES];
    logic [WORD_W-1:0] rd_word_reg;
    logic              mem_wr_en;
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic [WORD_W-1:0] mem_wr_word;

    // Control state.
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [CNT_W-1:0]  chk_pos_reg, chk_pos_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [CNT_W-1:0]  src_reg, src_next;
    logic [CNT_W-1:0]  wr_pos_reg, wr_pos_next;
    logic              wr_pend_reg, wr_pend_next;
    logic              m_valid_reg, m_valid_next;

    // Transaction held during its work, and the pending result.
    cmd_t              cmd_reg, cmd_next;
    logic [ID_W-1:0]   id_reg, id_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] found_reg, found_next;
    out_item_t         out_reg, out_next;

    // Search and compaction conditions.
    logic              id_match;
    logic              hit;
    logic              miss;
    logic              shift_done;
    logic              out_free;
    logic [CNT_W-1:0]  room;

    assign id_match   = (rd_word_reg[WORD_W-1:DATA_W] == id_reg);
    assign hit        = chk_valid_reg && id_match;
    assign miss       = chk_valid_reg && !id_match && (remain_reg == '0);
    assign shift_done = (src_reg >= count_reg) && !wr_pend_reg;
    assign out_free   = !m_valid_reg || m_ready;
    assign room       = ENT_FULL - count_reg;

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    // Memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            mem[mem_wr_addr] <= mem_wr_word;
        end
        if (mem_rd_en) begin
            rd_word_reg <= mem[mem_rd_addr];
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (s_item.command)
                        CMD_READ, CMD_ERASE: begin
                            state_next = (count_reg == '0) ? S_EMIT : S_SEARCH;
                        end
                        default: begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    state_next = (cmd_reg == CMD_ERASE) ? S_SHIFT : S_EMIT;
                end else if (miss) begin
                    state_next = S_EMIT;
                end
            end
            S_SHIFT: begin
                if (shift_done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, memory accesses and handshake outputs.
    always_comb begin
        s_ready        = 1'b0;
        mem_wr_en      = 1'b0;
        mem_rd_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_rd_addr    = '0;
        mem_wr_word    = '0;
        head_next      = head_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        remain_next    = remain_reg;
        chk_pos_next   = chk_pos_reg;
        chk_valid_next = chk_valid_reg;
        src_next       = src_reg;
        wr_pos_next    = wr_pos_reg;
        wr_pend_next   = wr_pend_reg;
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next       = s_item.command;
                    id_next        = s_item.log_id;
                    found_next     = '0;
                    chk_valid_next = 1'b0;
                    case (s_item.command)
                        CMD_WRITE: begin
                            // Append; a full table drops its oldest entry.
                            mem_wr_en   = 1'b1;
                            mem_wr_word = {s_item.log_id, s_item.log_data};
                            if (count_reg == ENT_FULL) begin
                                mem_wr_addr = head_reg;
                                head_next   = (head_reg == IDX_W'(ENTRIES - 1)) ?
                                              '0 : head_reg + 1'b1;
                                status_next = ST_EVICTED;
                            end else begin
                                mem_wr_addr = phys(head_reg, count_reg);
                                count_next  = count_reg + 1'b1;
                                status_next = ST_STORED;
                            end
                        end
                        CMD_READ: begin
                            status_next = ST_MISSING;
                            scan_next   = count_reg - 1'b1;
                            remain_next = count_reg;
                        end
                        CMD_ERASE: begin
                            status_next = ST_MISSING;
                            scan_next   = '0;
                            remain_next = count_reg;
                        end
                        default: begin
                            status_next = ST_STORED;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // Issue the next read; its word is compared in the next cycle.
                if (remain_reg != '0) begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = phys(head_reg, scan_reg);
                    chk_pos_next   = scan_reg;
                    chk_valid_next = 1'b1;
                    remain_next    = remain_reg - 1'b1;
                    scan_next      = (cmd_reg == CMD_READ) ? scan_reg - 1'b1 :
                                                             scan_reg + 1'b1;
                end else begin
                    chk_valid_next = 1'b0;
                end
                if (hit) begin
                    chk_valid_next = 1'b0;
                    if (cmd_reg == CMD_READ) begin
                        found_next  = rd_word_reg[DATA_W-1:0];
                        status_next = ST_FOUND;
                    end else begin
                        src_next     = chk_pos_reg + 1'b1;
                        wr_pend_next = 1'b0;
                    end
                end
            end
            S_SHIFT: begin
                // Close the gap: each later entry moves down one place.
                if (wr_pend_reg) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = phys(head_reg, wr_pos_reg);
                    mem_wr_word = rd_word_reg;
                end
                if (src_reg < count_reg) begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = phys(head_reg, src_reg);
                    wr_pend_next = 1'b1;
                    wr_pos_next  = src_reg - 1'b1;
                    src_next     = src_reg + 1'b1;
                end else begin
                    wr_pend_next = 1'b0;
                end
                if (shift_done) begin
                    count_next  = count_reg - 1'b1;
                    status_next = ST_ERASED;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    out_next.status      = status_reg;
                    out_next.found_data  = found_reg;
                    out_next.entry_count = COUNT_W'(count_reg);
                    out_next.free_bytes  = FREE_W'(room) << ENTRY_SHIFT;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
            wr_pend_reg   <= wr_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        scan_reg    <= scan_next;
        remain_reg  <= remain_next;
        chk_pos_reg <= chk_pos_next;
        src_reg     <= src_next;
        wr_pos_reg  <= wr_pos_next;
        cmd_reg     <= cmd_next;
        id_reg      <= id_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        out_reg     <= out_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/logtab_checker.sv =====
// Port-level checks for the log table, and the bind that attaches them.
// Depends on logtab_pkg and log_table_with_id_lookup.
`default_nettype none

module logtab_checker (
    input wire                   aclk,
    input wire                   aresetn,
    input wire                   m_valid,
    input wire                   m_ready,
    input logtab_pkg::out_item_t m_item
);
    import logtab_pkg::*;

    // No result transaction is offered straight after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // Free bytes and entry count always account for the whole store.
    a_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_item.free_bytes) + 32'(m_item.entry_count) * ENTRY_BYTES
                     == ENTRIES * ENTRY_BYTES))
        else $error("free bytes and entry count disagree");

    // Data is returned only with a successful read.
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status != ST_FOUND) |-> m_item.found_data == '0)
        else $error("data returned without a hit");

    // Eviction only happens on a full table.
    a_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.status == ST_EVICTED) |->
            32'(m_item.entry_count) == ENTRIES)
        else $error("eviction reported on a table that is not full");

endmodule

bind log_table_with_id_lookup logtab_checker u_logtab_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire
